// File: rtl/core/pcpe_pkg.sv
package pcpe_pkg;

    localparam int unsigned PREFIX_BYTES  = 32;
    localparam int unsigned TRAILER_BYTES = 4;
    localparam int unsigned HASH_BYTES    = 16;
    localparam int unsigned CNT_W         = 33;
    localparam int unsigned FIFO_DEPTH    = 4;
    localparam int unsigned FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

    localparam logic [31:0] CHUNK_TYPE_RST    = 32'h6543_684F;
    localparam logic [63:0] PAYLOAD_MAGIC_RST = 64'h4543_484F_504E_4731;

    localparam logic [1:0] CFG_CHUNK_TYPE    = 2'd0;
    localparam logic [1:0] CFG_PAYLOAD_MAGIC = 2'd1;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_HASH    = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_CORRUPT = 1'b1;

    typedef enum logic [3:0] {
        PH_SIG,
        PH_LEN,
        PH_TYPE,
        PH_SKIP,
        PH_MAGIC,
        PH_PLEN,
        PH_HASH,
        PH_PAY,
        PH_REST
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       status;
        logic       fin;
    } res_t;

    // up to two results per input beat, first one in e0
    typedef struct packed {
        logic [1:0] n;
        res_t       e0;
        res_t       e1;
    } push_t;

    function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0: b = 8'd137;
            3'd1: b = 8'd80;
            3'd2: b = 8'd78;
            3'd3: b = 8'd71;
            3'd4: b = 8'd13;
            3'd5: b = 8'd10;
            3'd6: b = 8'd26;
            3'd7: b = 8'd10;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    function automatic res_t status_res(input logic st);
        res_t r;
        r.kind   = KIND_STATUS;
        r.data   = 8'd0;
        r.status = st;
        r.fin    = 1'b1;
        return r;
    endfunction

    function automatic res_t data_res(input logic [1:0] k, input logic [7:0] d);
        res_t r;
        r.kind   = k;
        r.data   = d;
        r.status = STATUS_OK;
        r.fin    = 1'b0;
        return r;
    endfunction

endpackage

// File: rtl/core/png_chunk_payload_extract.sv
// A result beat reaches m_ through the queue write and then the output register.
// Throughput: one input byte per cycle while s_tready is high; one result beat per cycle out while m_tready is high.
// The last byte of a stream may give two results; a 4-entry result queue
// absorbs them and s_tready drops while fewer than two entries are free.
// Reset (aresetn low, synchronous): registers back to defaults, parser to
// signature check, queue and output stage emptied.
module png_chunk_payload_extract (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [8] status_code, rest zero
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    output logic        m_tlast,   // final_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import pcpe_pkg::*;

    push_t push;
    res_t  q_head;
    logic  q_not_empty;
    logic  q_pop;
    logic  accept;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    pcpe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_byte   (s_tdata),
        .is_last   (s_tlast),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push)
    );

    pcpe_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (q_pop),
        .in_ready  (s_tready),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    pcpe_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // status beats always close the run
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_STATUS) |-> m_tlast && (m_tdata[7:0] == 8'd0))
        else $error("status beat without tlast or with data");

    a_data_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != KIND_STATUS) |-> !m_tlast && !m_tdata[8])
        else $error("data beat flagged as final or corrupted");

    // a queue with fewer than two free entries implies a loaded output stage
    a_stall_backed: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output stage");

    a_one_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_tvalid)
        else $error("popped result not presented");

endmodule

// File: rtl/core/pcpe_front.sv
module pcpe_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    input  logic              is_last,
    input  logic              cfg_wr,
    input  logic [1:0]        cfg_index,
    input  logic [63:0]       cfg_data,
    output pcpe_pkg::push_t   push
);
    import pcpe_pkg::*;

    logic [31:0]      type_code_reg;
    logic [63:0]      magic_reg;

    phase_t           phase_reg,   phase_next;
    logic [CNT_W-1:0] cnt_reg,     cnt_next;
    logic [31:0]      chunk_reg,   chunk_next;
    logic [63:0]      shift_reg,   shift_next;
    logic [63:0]      plen_reg,    plen_next;
    logic [CNT_W-1:0] rest_reg,    rest_next;
    logic             decided_reg, decided_next;

    logic             v0, v1;
    res_t             r0, r1;
    logic [CNT_W-1:0] room;
    logic [CNT_W-1:0] chunk_ext;

    assign chunk_ext = {1'b0, chunk_reg};
    assign room      = chunk_ext - CNT_W'(PREFIX_BYTES);

    always_comb begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        chunk_next   = chunk_reg;
        shift_next   = shift_reg;
        plen_next    = plen_reg;
        rest_next    = rest_reg;
        decided_next = decided_reg;
        v0           = 1'b0;
        v1           = 1'b0;
        r0           = status_res(STATUS_CORRUPT);
        r1           = status_res(STATUS_CORRUPT);

        if (!decided_reg) begin
            unique case (phase_reg)
                PH_SIG: begin
                    if (in_byte != png_sig_byte(cnt_reg[2:0])) begin
                        v0           = 1'b1;
                        decided_next = 1'b1;
                    end else if (cnt_reg == CNT_W'(7)) begin
                        phase_next = PH_LEN;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                PH_LEN: begin
                    chunk_next = {chunk_reg[23:0], in_byte};
                    if (cnt_reg == CNT_W'(3)) begin
                        phase_next = PH_TYPE;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                PH_TYPE: begin
                    shift_next = {shift_reg[55:0], in_byte};
                    if (cnt_reg == CNT_W'(3)) begin
                        if (shift_next[31:0] == type_code_reg &&
                            chunk_reg >= 32'(PREFIX_BYTES)) begin
                            phase_next = PH_MAGIC;
                            cnt_next   = '0;
                        end else begin
                            phase_next = PH_SKIP;
                            cnt_next   = chunk_ext + CNT_W'(TRAILER_BYTES);
                        end
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                PH_SKIP: begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        phase_next = PH_LEN;
                    end
                end
                PH_MAGIC: begin
                    shift_next = {shift_reg[55:0], in_byte};
                    if (cnt_reg == CNT_W'(7)) begin
                        if (shift_next == magic_reg) begin
                            phase_next = PH_PLEN;
                            cnt_next   = '0;
                        end else begin
                            // rest of the data after the magic, plus CRC
                            phase_next = PH_SKIP;
                            cnt_next   = chunk_ext - CNT_W'(8) + CNT_W'(TRAILER_BYTES);
                        end
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                PH_PLEN: begin
                    plen_next = {plen_reg[55:0], in_byte};
                    if (cnt_reg == CNT_W'(7)) begin
                        if (plen_next > {{(64-CNT_W){1'b0}}, room}) begin
                            v0           = 1'b1;
                            decided_next = 1'b1;
                        end else begin
                            rest_next  = room - plen_next[CNT_W-1:0]
                                         + CNT_W'(TRAILER_BYTES);
                            phase_next = PH_HASH;
                            cnt_next   = '0;
                        end
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                PH_HASH: begin
                    v0 = 1'b1;
                    r0 = data_res(KIND_HASH, in_byte);
                    if (cnt_reg == CNT_W'(HASH_BYTES - 1)) begin
                        if (plen_reg == 64'd0) begin
                            phase_next = PH_REST;
                            cnt_next   = rest_reg;
                        end else begin
                            phase_next = PH_PAY;
                            cnt_next   = plen_reg[CNT_W-1:0];
                        end
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                PH_PAY: begin
                    v0       = 1'b1;
                    r0       = data_res(KIND_PAYLOAD, in_byte);
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        phase_next = PH_REST;
                        cnt_next   = rest_reg;
                    end
                end
                PH_REST: begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        v0           = 1'b1;
                        r0           = status_res(STATUS_OK);
                        decided_next = 1'b1;
                    end
                end
                default: begin
                    v0           = 1'b1;
                    decided_next = 1'b1;
                end
            endcase
        end

        if (is_last) begin
            v1           = !decided_next;
            phase_next   = PH_SIG;
            cnt_next     = '0;
            chunk_next   = '0;
            shift_next   = '0;
            plen_next    = '0;
            rest_next    = '0;
            decided_next = 1'b0;
        end
    end

    always_comb begin
        push.e0 = v0 ? r0 : r1;
        push.e1 = r1;
        push.n  = accept ? ({1'b0, v0} + {1'b0, v1}) : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            type_code_reg <= CHUNK_TYPE_RST;
            magic_reg     <= PAYLOAD_MAGIC_RST;
        end else if (cfg_wr) begin
            if (cfg_index == CFG_CHUNK_TYPE) begin
                type_code_reg <= cfg_data[31:0];
            end else if (cfg_index == CFG_PAYLOAD_MAGIC) begin
                magic_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SIG;
            cnt_reg     <= '0;
            chunk_reg   <= '0;
            shift_reg   <= '0;
            plen_reg    <= '0;
            rest_reg    <= '0;
            decided_reg <= 1'b0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            chunk_reg   <= chunk_next;
            shift_reg   <= shift_next;
            plen_reg    <= plen_next;
            rest_reg    <= rest_next;
            decided_reg <= decided_next;
        end
    end

endmodule

// File: rtl/core/pcpe_fifo.sv
module pcpe_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  pcpe_pkg::push_t push,
    input  logic            pop,
    output logic            in_ready,
    output logic            not_empty,
    output pcpe_pkg::res_t  head
);
    import pcpe_pkg::*;

    res_t                  mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg,  count_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_p1;
    logic                  do_pop;

    assign wr_ptr_p1 = wr_ptr_reg + FIFO_PTR_W'(1);
    assign not_empty = (count_reg != '0);
    assign do_pop    = pop && not_empty;
    // room for a two-result beat
    assign in_ready  = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(do_pop);
        count_next  = count_reg + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem[wr_ptr_reg] <= push.e0;
        end
        if (push.n == 2'd2) begin
            mem[wr_ptr_p1] <= push.e1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/pcpe_back.sv
module pcpe_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_not_empty,
    input  pcpe_pkg::res_t  q_head,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [15:0]     m_tdata,
    output logic [1:0]      m_tuser,
    output logic            m_tlast
);
    import pcpe_pkg::*;

    logic valid_reg, valid_next;
    res_t out_reg;

    assign q_pop      = q_not_empty && (!valid_reg || m_tready);
    assign valid_next = q_pop || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= q_head;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, out_reg.status, out_reg.data};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.fin;

endmodule

// File: tb/tb_png_chunk_payload_extract.sv
`timescale 1ns / 100ps

module tb_png_chunk_payload_extract;
    import pcpe_pkg::*;

    localparam int CYCLE_LIMIT       = 200000;
    localparam int ITEMS_PER_SETTING = 45;
    localparam int SETTINGS_COUNT    = 5;

    typedef enum logic [1:0] {
        BY_MODEL,
        NO_BEAT,
        CORRUPT_END
    } row_want_t;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
        row_want_t  want;
    } row_t;

    localparam logic [7:0] PNG_SIG [8] = '{
        8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10
    };

    localparam row_t DIR_ROWS [22] = '{
        '{8'h00, 1'b0, CORRUPT_END},
        '{8'hFF, 1'b0, NO_BEAT},
        '{8'h89, 1'b1, NO_BEAT},
        '{8'h89, 1'b1, CORRUPT_END},
        '{8'h89, 1'b0, BY_MODEL},
        '{8'h50, 1'b0, BY_MODEL},
        '{8'h4E, 1'b0, BY_MODEL},
        '{8'h47, 1'b0, BY_MODEL},
        '{8'h0D, 1'b0, BY_MODEL},
        '{8'h0A, 1'b0, BY_MODEL},
        '{8'h1A, 1'b0, BY_MODEL},
        '{8'h0A, 1'b0, BY_MODEL},
        '{8'h00, 1'b0, BY_MODEL},
        '{8'h00, 1'b0, BY_MODEL},
        '{8'h00, 1'b0, BY_MODEL},
        '{8'h00, 1'b0, BY_MODEL},
        '{8'h49, 1'b0, BY_MODEL},
        '{8'h45, 1'b0, BY_MODEL},
        '{8'h4E, 1'b0, BY_MODEL},
        '{8'h44, 1'b0, BY_MODEL},
        '{8'hAE, 1'b0, BY_MODEL},
        '{8'h42, 1'b1, BY_MODEL}
    };

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [63:0] cfg_data  = 64'd0;

    // parser copy
    logic [31:0] marker_type  = CHUNK_TYPE_RST;
    logic [63:0] marker_magic = PAYLOAD_MAGIC_RST;
    phase_t      ph           = PH_SIG;
    logic [32:0] cnt          = '0;
    logic [31:0] clen         = '0;
    logic [63:0] shift        = '0;
    logic [63:0] plen         = '0;
    bit          decided      = 1'b0;

    res_t        results_due [$];
    logic [7:0]  file_bytes [$];
    int          mismatches = 0;
    int          cycle_cnt  = 0;
    bit          steady     = 1'b0;

    png_chunk_payload_extract dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic res_t mk_res(logic [1:0] k, logic [7:0] d, logic st, logic f);
        res_t r;
        r.kind   = k;
        r.data   = d;
        r.status = st;
        r.fin    = f;
        return r;
    endfunction

    task automatic due(input res_t r, input bit keep);
        if (keep) begin
            results_due.push_back(r);
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input bit last, input bit keep);
        logic [63:0] room;
        if (!decided) begin
            case (ph)
                PH_SIG: begin
                    if (b != PNG_SIG[cnt[2:0]]) begin
                        due(mk_res(KIND_STATUS, 8'd0, STATUS_CORRUPT, 1'b1), keep);
                        decided = 1'b1;
                    end else begin
                        cnt = cnt + 1;
                        if (cnt == 8) begin
                            ph  = PH_LEN;
                            cnt = '0;
                        end
                    end
                end
                PH_LEN: begin
                    clen = {clen[23:0], b};
                    cnt  = cnt + 1;
                    if (cnt == 4) begin
                        ph  = PH_TYPE;
                        cnt = '0;
                    end
                end
                PH_TYPE: begin
                    shift = {shift[55:0], b};
                    cnt   = cnt + 1;
                    if (cnt == 4) begin
                        if (shift[31:0] == marker_type && clen >= PREFIX_BYTES) begin
                            ph  = PH_MAGIC;
                            cnt = '0;
                        end else begin
                            ph  = PH_SKIP;
                            cnt = {1'b0, clen} + 33'(TRAILER_BYTES);
                        end
                    end
                end
                PH_SKIP: begin
                    cnt = cnt - 1;
                    if (cnt == 0) begin
                        ph = PH_LEN;
                    end
                end
                PH_MAGIC: begin
                    shift = {shift[55:0], b};
                    cnt   = cnt + 1;
                    if (cnt == 8) begin
                        if (shift == marker_magic) begin
                            ph  = PH_PLEN;
                            cnt = '0;
                        end else begin
                            ph  = PH_SKIP;
                            cnt = {1'b0, clen} - 33'd8 + 33'(TRAILER_BYTES);
                        end
                    end
                end
                PH_PLEN: begin
                    plen = {plen[55:0], b};
                    cnt  = cnt + 1;
                    if (cnt == 8) begin
                        room = {32'd0, clen} - 64'(PREFIX_BYTES);
                        if (plen > room) begin
                            due(mk_res(KIND_STATUS, 8'd0, STATUS_CORRUPT, 1'b1), keep);
                            decided = 1'b1;
                        end else begin
                            shift = room - plen + 64'(TRAILER_BYTES);
                            ph    = PH_HASH;
                            cnt   = '0;
                        end
                    end
                end
                PH_HASH: begin
                    due(mk_res(KIND_HASH, b, STATUS_OK, 1'b0), keep);
                    cnt = cnt + 1;
                    if (cnt == HASH_BYTES) begin
                        if (plen == 0) begin
                            ph  = PH_REST;
                            cnt = shift[32:0];
                        end else begin
                            ph  = PH_PAY;
                            cnt = plen[32:0];
                        end
                    end
                end
                PH_PAY: begin
                    due(mk_res(KIND_PAYLOAD, b, STATUS_OK, 1'b0), keep);
                    cnt = cnt - 1;
                    if (cnt == 0) begin
                        ph  = PH_REST;
                        cnt = shift[32:0];
                    end
                end
                PH_REST: begin
                    cnt = cnt - 1;
                    if (cnt == 0) begin
                        due(mk_res(KIND_STATUS, 8'd0, STATUS_OK, 1'b1), keep);
                        decided = 1'b1;
                    end
                end
                default: begin
                    due(mk_res(KIND_STATUS, 8'd0, STATUS_CORRUPT, 1'b1), keep);
                    decided = 1'b1;
                end
            endcase
        end
        if (last) begin
            if (!decided) begin
                due(mk_res(KIND_STATUS, 8'd0, STATUS_CORRUPT, 1'b1), keep);
            end
            ph      = PH_SIG;
            cnt     = '0;
            clen    = '0;
            shift   = '0;
            plen    = '0;
            decided = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_cnt);
        mismatches++;
    endtask

    task automatic send_byte(input logic [7:0] b, input bit last, input bit keep);
        while (!steady && $urandom_range(0, 99) < 11) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        parse_byte(b, last, keep);
    endtask

    task automatic write_settings(input logic [31:0] t, input logic [63:0] m);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_CHUNK_TYPE;
        cfg_data  <= {32'd0, t};
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= CFG_PAYLOAD_MAGIC;
        cfg_data  <= m;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid    <= 1'b0;
        marker_type  = t;
        marker_magic = m;
    endtask

    task automatic settle(input int extra);
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic add_be(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) begin
            file_bytes.push_back(v[8*i +: 8]);
        end
    endtask

    task automatic add_rand(input int n);
        repeat (n) file_bytes.push_back(8'($urandom));
    endtask

    task automatic build_file();
        int          pick;
        int          len;
        int          plen_i;
        int          extra;
        int          keep_n;
        logic [63:0] plen_v;
        file_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            add_rand($urandom_range(1, 12));
        end else begin
            for (int i = 0; i < 8; i++) file_bytes.push_back(PNG_SIG[i]);
            if (pick < 16) begin
                file_bytes[$urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
            end
            repeat ($urandom_range(0, 2)) begin
                len = $urandom_range(0, 6);
                add_be(64'(len), 4);
                add_be(64'($urandom), 4);
                add_rand(len + 4);
            end
            // decoys: marked but short, or marked without the magic
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1) == 1) begin
                    len = $urandom_range(0, 31);
                    add_be(64'(len), 4);
                    add_be({32'd0, marker_type}, 4);
                    add_rand(len + 4);
                end else begin
                    len = $urandom_range(32, 40);
                    add_be(64'(len), 4);
                    add_be({32'd0, marker_type}, 4);
                    add_be(marker_magic ^ (64'd1 << $urandom_range(0, 63)), 8);
                    add_rand(len - 8 + 4);
                end
            end
            if ($urandom_range(0, 99) < 85) begin
                plen_i = $urandom_range(0, 5);
                extra  = $urandom_range(0, 3);
                plen_v = 64'(plen_i);
                if ($urandom_range(0, 99) < 15) begin
                    plen_v = ($urandom_range(0, 1) == 1) ? 64'(plen_i + extra + 1)
                                                         : {1'b1, 31'($urandom), $urandom};
                end
                add_be(64'(32 + plen_i + extra), 4);
                add_be({32'd0, marker_type}, 4);
                add_be(marker_magic, 8);
                add_be(plen_v, 8);
                add_rand(16 + plen_i + extra + 4);
            end
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                // huge length field, stream cut short
                add_be(64'($urandom), 4);
                if ($urandom_range(0, 1) == 1) begin
                    add_be({32'd0, marker_type}, 4);
                    add_be(marker_magic, 8);
                    if ($urandom_range(0, 1) == 1) begin
                        add_be(64'($urandom_range(0, 1000)), 8);
                    end
                end else begin
                    add_be(64'($urandom), 4);
                end
                add_rand($urandom_range(0, 20));
            end else if (pick < 30) begin
                add_rand($urandom_range(1, 5));
            end
            if ($urandom_range(0, 99) < 20) begin
                keep_n = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > keep_n) void'(file_bytes.pop_back());
            end
        end
    endtask

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                report_mismatch("unexpected beat", {62'd0, m_tuser}, 64'd0);
            end else begin
                want = results_due.pop_front();
                if (m_tuser !== want.kind) begin
                    report_mismatch("result_kind", {62'd0, m_tuser}, {62'd0, want.kind});
                end
                if (m_tdata[7:0] !== want.data) begin
                    report_mismatch("data_byte", {56'd0, m_tdata[7:0]}, {56'd0, want.data});
                end
                if (m_tdata[8] !== want.status) begin
                    report_mismatch("status_code", {63'd0, m_tdata[8]}, {63'd0, want.status});
                end
                if (m_tlast !== want.fin) begin
                    report_mismatch("final_res", {63'd0, m_tlast}, {63'd0, want.fin});
                end
            end
        end
        m_tready <= steady || ($urandom_range(0, 99) >= 11);
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int sent;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIR_ROWS[i]) begin
            send_byte(DIR_ROWS[i].b, DIR_ROWS[i].last, DIR_ROWS[i].want == BY_MODEL);
            if (DIR_ROWS[i].want == CORRUPT_END) begin
                results_due.push_back(mk_res(KIND_STATUS, 8'd0, STATUS_CORRUPT, 1'b1));
            end
        end

        for (int setting = 0; setting < SETTINGS_COUNT; setting++) begin
            if (setting != 0) begin
                settle(8);
                case (setting)
                    1: write_settings(32'd0, 64'd0);
                    2: write_settings('1, '1);
                    3: write_settings($urandom, {$urandom, $urandom});
                    default: write_settings(CHUNK_TYPE_RST, PAYLOAD_MAGIC_RST);
                endcase
            end
            steady = (setting == 2);
            sent = 0;
            while (sent < ITEMS_PER_SETTING) begin
                build_file();
                foreach (file_bytes[i]) begin
                    send_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b1);
                end
                sent += file_bytes.size();
            end
        end

        settle(10);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/pcpe_pkg.sv
rtl/core/pcpe_front.sv
rtl/core/pcpe_fifo.sv
rtl/core/pcpe_back.sv
rtl/core/png_chunk_payload_extract.sv
tb/tb_png_chunk_payload_extract.sv
